>>> sv/tbi_pkg.sv
// Shared types and constants for the toroidal body integrator.
// Used by the controller, the datapath and the top level.
package tbi_pkg;

    localparam int POS_FRAC = 8;
    localparam int IN_W     = 128;
    localparam int OUT_W    = 232;

    // smallest d^2 in Q.2P square pixels (0.01, rounded)
    localparam logic [41:0] MIN_D2 = 42'(((1 << (2 * POS_FRAC)) + 50) / 100);

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_AX,
        OP_AY,
        OP_RT,
        OP_VX,
        OP_VY,
        OP_MODX,
        OP_WRAPX,
        OP_MODY,
        OP_WRAPY,
        OP_DIFF,
        OP_SQX,
        OP_SQY,
        OP_SSUM,
        OP_MAG_DIV,
        OP_MAG,
        OP_TX,
        OP_T0,
        OP_T1,
        OP_T2,
        OP_T3,
        OP_T4,
        OP_CDIV,
        OP_CSQ,
        OP_GCOMP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic axis_y;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic s_zero;
    } stat_t;

    // packed so that the last field (accel_x) sits in the lowest bits
    typedef struct packed {
        logic [2:0]         pad;
        logic [19:0]        query_y;
        logic [19:0]        query_x;
        logic [15:0]        time_step;
        logic signed [20:0] turn_rate;
        logic signed [23:0] accel_y;
        logic signed [23:0] accel_x;
    } in_t;

    typedef struct packed {
        logic signed [31:0] grav_y;
        logic signed [31:0] grav_x;
        logic [47:0]        elapsed;
        logic signed [15:0] heading;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic [19:0]        pos_y;
        logic [19:0]        pos_x;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] x);
        logic signed [31:0] r;
        if (x > 51'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -51'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

>>> sv/tbi_divider.sv
// Restoring divider, one quotient bit per cycle.
// Remainder can be preloaded; dividend is taken MSB first from num_init.
module tbi_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [41:0] rem_init,
    input  logic [63:0] num_init,
    input  logic [41:0] den,
    input  logic [6:0]  iters,
    output logic        busy,
    output logic [63:0] quo,
    output logic [41:0] rem
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [41:0] rem_reg;
    logic [41:0] den_reg;
    logic [63:0] num_reg;
    logic [63:0] quo_reg;
    logic [42:0] trial;
    logic [42:0] diff;
    logic        ge;

    assign trial = {rem_reg, num_reg[63]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= iters - 7'd1;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            num_reg <= num_init;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[41:0] : trial[41:0];
            num_reg <= {num_reg[62:0], 1'b0};
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> sv/tbi_isqrt.sv
// Digit-by-digit integer square root of a 62-bit value, one root bit per cycle.
// Standalone; no package dependency.
module tbi_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [61:0] x,
    output logic        busy,
    output logic [30:0] root
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [61:0] x_reg;
    logic [32:0] rem_reg;
    logic [30:0] root_reg;
    logic [34:0] r4;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;

    assign r4    = {rem_reg, x_reg[61:60]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = r4 >= trial;
    assign diff  = r4 - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd30;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[59:0], 2'b00};
            rem_reg  <= ge ? diff[32:0] : r4[32:0];
            root_reg <= {root_reg[29:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

>>> sv/tbi_datapath.sv
// Datapath: body state, one shared multiplier, divider and square-root units.
// Depends on tbi_pkg, tbi_divider and tbi_isqrt; driven by tbi_ctrl commands.
module tbi_datapath
    import tbi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  in_t         in_data,
    input  logic [31:0] grav_g,
    input  logic [11:0] world_w,
    input  logic [11:0] world_h,
    output stat_t       stat,
    output res_t        res
);

    localparam logic [6:0] ITERS_WRAP = 7'd33;
    localparam logic [6:0] ITERS_MAG  = 7'd48;
    localparam logic [6:0] ITERS_COMP = 7'd62;

    // body state
    logic [19:0]        px_reg;
    logic [19:0]        py_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic [15:0]        hd_reg;
    logic [47:0]        el_reg;

    // item and scratch
    logic signed [23:0] ax_reg;
    logic signed [23:0] ay_reg;
    logic signed [20:0] rate_reg;
    logic [15:0]        dt_reg;
    logic [19:0]        qx_reg;
    logic [19:0]        qy_reg;
    logic signed [65:0] prod_reg;
    logic signed [33:0] sumx_reg;
    logic signed [33:0] sumy_reg;
    logic signed [20:0] dx_reg;
    logic signed [20:0] dy_reg;
    logic [41:0]        s_reg;
    logic [30:0]        mag_reg;
    logic [50:0]        t_reg;
    logic [101:0]       acc_reg;
    logic signed [31:0] gx_reg;
    logic signed [31:0] gy_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [50:0] prod_sh;
    logic signed [50:0] vx_sum;
    logic signed [50:0] vy_sum;
    logic signed [50:0] px_sum;
    logic signed [50:0] py_sum;
    logic [48:0]        el_sum;
    logic [20:0]        span_x;
    logic [20:0]        span_y;
    logic [32:0]        abs_x;
    logic [32:0]        abs_y;
    logic [20:0]        wrap_x;
    logic [20:0]        wrap_y;
    logic signed [20:0] d_sel;
    logic [20:0]        d_abs;
    logic [41:0]        s_min;
    logic [30:0]        mag_sat;
    logic signed [31:0] root_c;
    logic signed [31:0] g_comp;

    logic        div_start;
    logic [41:0] div_rem_init;
    logic [63:0] div_num;
    logic [41:0] div_den;
    logic [6:0]  div_iters;
    logic        div_busy;
    logic [63:0] div_quo;
    logic [41:0] div_rem;
    logic        sqrt_busy;
    logic [30:0] sqrt_root;

    assign prod_sh = {prod_reg[65], prod_reg[65:16]};
    assign vx_sum  = $signed({{19{vx_reg[31]}}, vx_reg}) + prod_sh;
    assign vy_sum  = $signed({{19{vy_reg[31]}}, vy_reg}) + prod_sh;
    assign px_sum  = $signed({31'b0, px_reg}) + prod_sh;
    assign py_sum  = $signed({31'b0, py_reg}) + prod_sh;
    assign el_sum  = {1'b0, el_reg} + {33'b0, dt_reg};

    // a zero span acts as 4096 pixels
    assign span_x = {((world_w == 12'd0) ? 13'd4096 : {1'b0, world_w}), {POS_FRAC{1'b0}}};
    assign span_y = {((world_h == 12'd0) ? 13'd4096 : {1'b0, world_h}), {POS_FRAC{1'b0}}};

    assign abs_x = sumx_reg[33] ? 33'(-sumx_reg) : sumx_reg[32:0];
    assign abs_y = sumy_reg[33] ? 33'(-sumy_reg) : sumy_reg[32:0];

    assign wrap_x = (sumx_reg[33] && (div_rem[20:0] != 21'd0)) ? span_x - div_rem[20:0]
                                                               : div_rem[20:0];
    assign wrap_y = (sumy_reg[33] && (div_rem[20:0] != 21'd0)) ? span_y - div_rem[20:0]
                                                               : div_rem[20:0];

    assign d_sel   = cmd.axis_y ? dy_reg : dx_reg;
    assign d_abs   = d_sel[20] ? 21'(-d_sel) : d_sel;
    assign s_min   = (s_reg < MIN_D2) ? MIN_D2 : s_reg;
    assign mag_sat = (div_quo[63:31] != '0) ? '1 : div_quo[30:0];
    assign root_c  = $signed({1'b0, sqrt_root});
    assign g_comp  = d_sel[20] ? -root_c : root_c;

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_AX:
            begin
                mul_a = {{9{ax_reg[23]}}, ax_reg};
                mul_b = {17'b0, dt_reg};
            end
            OP_AY:
            begin
                mul_a = {{9{ay_reg[23]}}, ay_reg};
                mul_b = {17'b0, dt_reg};
            end
            OP_RT:
            begin
                mul_a = {{12{rate_reg[20]}}, rate_reg};
                mul_b = {17'b0, dt_reg};
            end
            OP_VX:
            begin
                mul_a = {vx_reg[31], vx_reg};
                mul_b = {17'b0, dt_reg};
            end
            OP_VY:
            begin
                mul_a = {vy_reg[31], vy_reg};
                mul_b = {17'b0, dt_reg};
            end
            OP_SQX:
            begin
                mul_a = {{12{dx_reg[20]}}, dx_reg};
                mul_b = {{12{dx_reg[20]}}, dx_reg};
            end
            OP_SQY:
            begin
                mul_a = {{12{dy_reg[20]}}, dy_reg};
                mul_b = {{12{dy_reg[20]}}, dy_reg};
            end
            OP_TX:
            begin
                mul_a = {2'b0, mag_reg};
                mul_b = {12'b0, d_abs};
            end
            OP_T1:
            begin
                mul_a = {8'b0, t_reg[50:26]};
                mul_b = {8'b0, t_reg[50:26]};
            end
            OP_T2:
            begin
                mul_a = {8'b0, t_reg[50:26]};
                mul_b = {7'b0, t_reg[25:0]};
            end
            OP_T3:
            begin
                mul_a = {7'b0, t_reg[25:0]};
                mul_b = {7'b0, t_reg[25:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider launch
    always_comb
    begin
        div_start    = 1'b0;
        div_rem_init = '0;
        div_num      = '0;
        div_den      = '0;
        div_iters    = ITERS_WRAP;
        unique case (cmd.op)
            OP_MODX:
            begin
                div_start = 1'b1;
                div_num   = {abs_x, 31'b0};
                div_den   = {21'b0, span_x};
            end
            OP_MODY:
            begin
                div_start = 1'b1;
                div_num   = {abs_y, 31'b0};
                div_den   = {21'b0, span_y};
            end
            OP_MAG_DIV:
            begin
                // G * 2^16 / m, as G*2^3P / (m*2^8)
                div_start = 1'b1;
                div_num   = {grav_g, 32'b0};
                div_den   = s_min;
                div_iters = ITERS_MAG;
            end
            OP_CDIV:
            begin
                // quotient stays below 2^62, so the top 40 bits preload the remainder
                div_start    = 1'b1;
                div_rem_init = {2'b0, acc_reg[101:62]};
                div_num      = {acc_reg[61:0], 2'b00};
                div_den      = s_reg;
                div_iters    = ITERS_COMP;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0;
            py_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
            hd_reg <= '0;
            el_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_AX:    el_reg <= el_sum[48] ? '1 : el_sum[47:0];
                OP_AY:    vx_reg <= sat32(vx_sum);
                OP_RT:    vy_reg <= sat32(vy_sum);
                OP_VX:    hd_reg <= hd_reg + prod_reg[31:16];
                OP_WRAPX: px_reg <= wrap_x[19:0];
                OP_WRAPY: py_reg <= wrap_y[19:0];
                default:  px_reg <= px_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                ax_reg   <= in_data.accel_x;
                ay_reg   <= in_data.accel_y;
                rate_reg <= in_data.turn_rate;
                dt_reg   <= in_data.time_step;
                qx_reg   <= in_data.query_x;
                qy_reg   <= in_data.query_y;
            end
            OP_VY:    sumx_reg <= px_sum[33:0];
            OP_MODX:  sumy_reg <= py_sum[33:0];
            OP_DIFF:
            begin
                dx_reg <= $signed({1'b0, px_reg}) - $signed({1'b0, qx_reg});
                dy_reg <= $signed({1'b0, py_reg}) - $signed({1'b0, qy_reg});
            end
            OP_SQY:   s_reg <= prod_reg[41:0];
            OP_SSUM:  s_reg <= s_reg + prod_reg[41:0];
            OP_MAG:
            begin
                mag_reg <= mag_sat;
                // coincident point: all of the pull goes on the y axis
                if (s_reg == 42'd0)
                begin
                    gx_reg <= '0;
                    gy_reg <= $signed({1'b0, mag_sat});
                end
            end
            OP_T0:    t_reg <= prod_reg[50:0];
            OP_T2:    acc_reg <= {prod_reg[49:0], 52'b0};
            OP_T3:    acc_reg <= acc_reg + {24'b0, prod_reg[50:0], 27'b0};
            OP_T4:    acc_reg <= acc_reg + {50'b0, prod_reg[51:0]};
            OP_GCOMP:
            begin
                if (cmd.axis_y)
                    gy_reg <= g_comp;
                else
                    gx_reg <= g_comp;
            end
            default:  t_reg <= t_reg;
        endcase

        unique case (cmd.op)
            OP_AX, OP_AY, OP_RT, OP_VX, OP_VY, OP_SQX, OP_SQY,
            OP_TX, OP_T1, OP_T2, OP_T3:
                prod_reg <= mul_a * mul_b;
            default:
                prod_reg <= prod_reg;
        endcase
    end

    tbi_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .num_init (div_num),
        .den      (div_den),
        .iters    (div_iters),
        .busy     (div_busy),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    tbi_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_CSQ),
        .x     (div_quo[61:0]),
        .busy  (sqrt_busy),
        .root  (sqrt_root)
    );

    assign stat.div_done  = !div_busy;
    assign stat.sqrt_done = !sqrt_busy;
    assign stat.s_zero    = (s_reg == 42'd0);

    assign res.pos_x   = px_reg;
    assign res.pos_y   = py_reg;
    assign res.vel_x   = vx_reg;
    assign res.vel_y   = vy_reg;
    assign res.heading = hd_reg;
    assign res.elapsed = el_reg;
    assign res.grav_x  = gx_reg;
    assign res.grav_y  = gy_reg;

endmodule

>>> sv/tbi_ctrl.sv
// Sequencer for one integration step; issues datapath commands.
// Depends on tbi_pkg.
module tbi_ctrl
    import tbi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_free,
    input  stat_t stat,
    output logic  in_ready,
    output logic  load_out,
    output cmd_t  cmd
);

    typedef enum logic [25:0] {
        ST_IDLE  = 26'd1 << 0,
        ST_AX    = 26'd1 << 1,
        ST_AY    = 26'd1 << 2,
        ST_RT    = 26'd1 << 3,
        ST_VX    = 26'd1 << 4,
        ST_VY    = 26'd1 << 5,
        ST_MODX  = 26'd1 << 6,
        ST_MODXW = 26'd1 << 7,
        ST_MODY  = 26'd1 << 8,
        ST_MODYW = 26'd1 << 9,
        ST_DIFF  = 26'd1 << 10,
        ST_SQX   = 26'd1 << 11,
        ST_SQY   = 26'd1 << 12,
        ST_SSUM  = 26'd1 << 13,
        ST_MAG   = 26'd1 << 14,
        ST_MAGW  = 26'd1 << 15,
        ST_TX    = 26'd1 << 16,
        ST_T0    = 26'd1 << 17,
        ST_T1    = 26'd1 << 18,
        ST_T2    = 26'd1 << 19,
        ST_T3    = 26'd1 << 20,
        ST_T4    = 26'd1 << 21,
        ST_CDIV  = 26'd1 << 22,
        ST_CDIVW = 26'd1 << 23,
        ST_CSQW  = 26'd1 << 24,
        ST_DONE  = 26'd1 << 25
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   axis_reg;
    logic   axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd.op     = OP_NOP;
        cmd.axis_y = axis_reg;
        in_ready   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_AX;
                end
            end
            ST_AX:   begin cmd.op = OP_AX;   state_next = ST_AY;   end
            ST_AY:   begin cmd.op = OP_AY;   state_next = ST_RT;   end
            ST_RT:   begin cmd.op = OP_RT;   state_next = ST_VX;   end
            ST_VX:   begin cmd.op = OP_VX;   state_next = ST_VY;   end
            ST_VY:   begin cmd.op = OP_VY;   state_next = ST_MODX; end
            ST_MODX: begin cmd.op = OP_MODX; state_next = ST_MODXW; end
            ST_MODXW:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_WRAPX;
                    state_next = ST_MODY;
                end
            end
            ST_MODY: begin cmd.op = OP_MODY; state_next = ST_MODYW; end
            ST_MODYW:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_WRAPY;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin cmd.op = OP_DIFF;    state_next = ST_SQX;  end
            ST_SQX:  begin cmd.op = OP_SQX;     state_next = ST_SQY;  end
            ST_SQY:  begin cmd.op = OP_SQY;     state_next = ST_SSUM; end
            ST_SSUM: begin cmd.op = OP_SSUM;    state_next = ST_MAG;  end
            ST_MAG:  begin cmd.op = OP_MAG_DIV; state_next = ST_MAGW; end
            ST_MAGW:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_MAG;
                    axis_next  = 1'b0;
                    state_next = stat.s_zero ? ST_DONE : ST_TX;
                end
            end
            ST_TX:   begin cmd.op = OP_TX;   state_next = ST_T0;   end
            ST_T0:   begin cmd.op = OP_T0;   state_next = ST_T1;   end
            ST_T1:   begin cmd.op = OP_T1;   state_next = ST_T2;   end
            ST_T2:   begin cmd.op = OP_T2;   state_next = ST_T3;   end
            ST_T3:   begin cmd.op = OP_T3;   state_next = ST_T4;   end
            ST_T4:   begin cmd.op = OP_T4;   state_next = ST_CDIV; end
            ST_CDIV: begin cmd.op = OP_CDIV; state_next = ST_CDIVW; end
            ST_CDIVW:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_CSQ;
                    state_next = ST_CSQW;
                end
            end
            ST_CSQW:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.op = OP_GCOMP;
                    if (axis_reg)
                        state_next = ST_DONE;
                    else
                    begin
                        axis_next  = 1'b1;
                        state_next = ST_TX;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/toroidal_body_integrator_top.sv
// One item in flight: a new transfer is taken only after the previous result has
// been loaded into the output register once the output is free. The shared divider
// does two wrap passes, a magnitude pass and, unless the query point coincides with
// the body, two component passes, each followed by a square-root pass; a finished
// result waits in the output register while the next item is taken. Reset (rst_n
// low, async) clears the body state, the result valid and the registers to defaults.
module toroidal_body_integrator_top
    import tbi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // accel_x[23:0], accel_y[47:24], turn_rate[68:48], time_step[84:69],
    // query_x[104:85], query_y[124:105], zero pad[127:125]
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    // pos_x[19:0], pos_y[39:20], vel_x[71:40], vel_y[103:72], heading[119:104],
    // elapsed[167:120], grav_x[199:168], grav_y[231:200]
    output logic [OUT_W-1:0]   m_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] REG_GRAV   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    logic [31:0]      grav_reg;
    logic [11:0]      width_reg;
    logic [11:0]      height_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             cfg_wr;
    logic             out_free;
    logic             load_out;
    cmd_t             cmd;
    stat_t            stat;
    res_t             res;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg   <= '0;
            width_reg  <= 12'd1920;
            height_reg <= 12'd1080;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_GRAV:   grav_reg   <= pwdata;
                REG_WIDTH:  width_reg  <= pwdata[11:0];
                REG_HEIGHT: height_reg <= pwdata[11:0];
                default:    grav_reg   <= grav_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_GRAV:   prdata = grav_reg;
            REG_WIDTH:  prdata = {20'b0, width_reg};
            REG_HEIGHT: prdata = {20'b0, height_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    tbi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_tready),
        .load_out (load_out),
        .cmd      (cmd)
    );

    tbi_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_data (in_t'(s_tdata)),
        .grav_g  (grav_reg),
        .world_w (width_reg),
        .world_h (height_reg),
        .stat    (stat),
        .res     (res)
    );

endmodule

>>> sv/tbi_checker.sv
// Port-level checks for the toroidal body integrator, bound to the top level.
// Sees only the top-level stream ports.
module tbi_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [231:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after input transfer");

    a_grav_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[199:168] != 32'h80000000) &&
                     (m_tdata[231:200] != 32'h80000000))
        else $error("attraction component beyond saturated magnitude");

endmodule

bind toroidal_body_integrator_top tbi_checker u_tbi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> dv/toroidal_body_integrator_top_tb.sv
// Self-checking testbench for toroidal_body_integrator_top: stream stimulus, APB setup,
// and a bit-exact motion and gravity predictor that checks every result transfer.
// Depends on tbi_pkg and the RTL top level only.
`timescale 1ns / 1ps

module toroidal_body_integrator_top_tb
    import tbi_pkg::*;
();

    localparam int REG_GRAVITY = 0;
    localparam int REG_WIDTH   = 1;
    localparam int REG_HEIGHT  = 2;
    localparam longint VEL_MAX = 64'sd2147483647;
    localparam longint VEL_MIN = -64'sd2147483648;
    localparam logic [47:0] AGE_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int POS_TOP = 1048319;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [OUT_W-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    toroidal_body_integrator_top DUT (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of the registers and the body state
    logic [31:0] g_cfg = 32'd0;
    logic [11:0] w_cfg = 12'd1920;
    logic [11:0] h_cfg = 12'd1080;
    longint bx_pos = 0, by_pos = 0, bx_vel = 0, by_vel = 0;
    logic [15:0] hdg = '0;
    logic [47:0] age = '0;

    in_t  pend_q[$];
    res_t expected_res_q[$];
    int   err_cnt = 0;
    int   n_ticks = 0;
    int   n_results = 0;

    function automatic longint clamp32(longint x);
        if (x > VEL_MAX)
            return VEL_MAX;
        if (x < VEL_MIN)
            return VEL_MIN;
        return x;
    endfunction

    function automatic longint wrap_span(longint p, logic [11:0] span_px);
        longint span;
        longint r;
        span = longint'(span_px == 0 ? 4096 : span_px) << POS_FRAC;
        r = p % span;
        if (r < 0)
            r += span;
        return r;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // |c| = sqrt(mag^2 * d^2 / s), sign of d
    function automatic longint grav_part(logic [63:0] mag, longint d, logic [63:0] s);
        logic [127:0] t;
        logic [63:0] ad;
        longint c;
        ad = (d < 0) ? -d : d;
        t = (128'(mag) * 128'(mag)) * (128'(ad) * 128'(ad));
        t = t / 128'(s);
        c = longint'(int_sqrt(t[63:0]));
        return (d < 0) ? -c : c;
    endfunction

    task automatic integrate_tick(input in_t it, output res_t r);
        longint dt, dx, dy, gx, gy;
        logic [48:0] age_sum;
        logic [63:0] s, m, mag;
        logic [127:0] q;
        dt = longint'(it.time_step);
        age_sum = 49'(age) + 49'(it.time_step);
        age = (age_sum > 49'(AGE_MAX)) ? AGE_MAX : age_sum[47:0];
        bx_vel = clamp32(bx_vel + ((longint'(it.accel_x) * dt) >>> 16));
        by_vel = clamp32(by_vel + ((longint'(it.accel_y) * dt) >>> 16));
        bx_pos = wrap_span(bx_pos + ((bx_vel * dt) >>> 16), w_cfg);
        by_pos = wrap_span(by_pos + ((by_vel * dt) >>> 16), h_cfg);
        hdg = hdg + 16'((longint'(it.turn_rate) * dt) >>> 16);
        dx = bx_pos - longint'(it.query_x);
        dy = by_pos - longint'(it.query_y);
        s = 64'(dx * dx) + 64'(dy * dy);
        m = (s < 64'(MIN_D2)) ? 64'(MIN_D2) : s;
        q = (128'(g_cfg) << (3 * POS_FRAC)) / (128'(m) << 8);
        mag = (q > 128'(VEL_MAX)) ? 64'(VEL_MAX) : q[63:0];
        if (s == 0)
        begin
            gx = 0;
            gy = longint'(mag);
        end
        else
        begin
            gx = grav_part(mag, dx, s);
            gy = grav_part(mag, dy, s);
        end
        r.pos_x = bx_pos[19:0];
        r.pos_y = by_pos[19:0];
        r.vel_x = bx_vel[31:0];
        r.vel_y = by_vel[31:0];
        r.heading = hdg;
        r.elapsed = age;
        r.grav_x = gx[31:0];
        r.grav_y = gy[31:0];
    endtask

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        in_t cur;
        res_t r;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            nv = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                integrate_tick(in_t'(s_tdata), r);
                expected_res_q.push_back(r);
                n_ticks++;
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pend_q.size() > 0)
                begin
                    cur = pend_q.pop_front();
                    s_tdata <= cur;
                    nv = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 400);
                    end
                    else
                        burst_left--;
                end
            end
            s_tvalid <= nv;
        end
    end

    // receiver: random stall pattern plus one long hold-off
    int rx_cycle = 0;
    int hold_cnt = 0;
    bit hold_done = 0;
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t exp_r;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata);
                n_results++;
                if (expected_res_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    err_cnt++;
                end
                else
                begin
                    exp_r = expected_res_q.pop_front();
                    check_field("pos_x", exp_r.pos_x, got.pos_x);
                    check_field("pos_y", exp_r.pos_y, got.pos_y);
                    check_field("vel_x", exp_r.vel_x, got.vel_x);
                    check_field("vel_y", exp_r.vel_y, got.vel_y);
                    check_field("heading", exp_r.heading, got.heading);
                    check_field("elapsed", exp_r.elapsed, got.elapsed);
                    check_field("grav_x", exp_r.grav_x, got.grav_x);
                    check_field("grav_y", exp_r.grav_y, got.grav_y);
                end
            end
            rx_cycle++;
            if (!hold_done && n_results == 60)
            begin
                hold_done = 1;
                hold_cnt = 4000;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if ((rx_cycle / 700) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    task automatic apb_write(input int idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(4 * idx);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GRAVITY: g_cfg = val;
            REG_WIDTH:   w_cfg = val[11:0];
            default:     h_cfg = val[11:0];
        endcase
    endtask

    task automatic set_world(input logic [31:0] g, input logic [11:0] w, input logic [11:0] h);
        apb_write(REG_GRAVITY, g);
        apb_write(REG_WIDTH, 32'(w));
        apb_write(REG_HEIGHT, 32'(h));
    endtask

    // all queued ticks sent and every result back, then let the block settle
    task automatic drain();
        @(negedge clk);
        while (pend_q.size() != 0 || expected_res_q.size() != 0 || s_tvalid)
            @(negedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic in_t make_tick(int ax, int ay, int rt, int dt, int qx, int qy);
        in_t it;
        it = '0;
        it.accel_x = 24'(ax);
        it.accel_y = 24'(ay);
        it.turn_rate = 21'(rt);
        it.time_step = 16'(dt);
        it.query_x = 20'(qx);
        it.query_y = 20'(qy);
        return it;
    endfunction

    function automatic int rand_accel();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 8388607 : -8388608;
            1: return int'($urandom_range(0, 16777215)) - 8388608;
            default: return int'($urandom_range(0, 8191)) - 4096;
        endcase
    endfunction

    function automatic in_t rand_tick();
        int dt;
        int qx;
        int qy;
        dt = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 2000);
        if ($urandom_range(0, 3) == 0)
        begin
            // query close to the body to exercise the near field
            qx = int'(bx_pos) + $urandom_range(0, 64) - 32;
            qy = int'(by_pos) + $urandom_range(0, 64) - 32;
            qx = (qx < 0) ? 0 : (qx > POS_TOP ? POS_TOP : qx);
            qy = (qy < 0) ? 0 : (qy > POS_TOP ? POS_TOP : qy);
        end
        else
        begin
            qx = $urandom_range(0, POS_TOP);
            qy = $urandom_range(0, POS_TOP);
        end
        return make_tick(rand_accel(), rand_accel(),
                         int'($urandom_range(0, 2097151)) - 1048576, dt, qx, qy);
    endfunction

    initial
    begin
        int g;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        set_world(32'h0010_0000, 12'd1920, 12'd1080);
        // field extremes, half-turn heading, zero and full time steps
        pend_q.push_back(make_tick(0, 0, 65536, 32768, 0, 0));
        pend_q.push_back(make_tick(0, 0, 0, 0, POS_TOP, POS_TOP));
        pend_q.push_back(make_tick(8388607, -8388608, 1048575, 65535, 0, POS_TOP));
        pend_q.push_back(make_tick(-8388608, 8388607, -1048576, 65535, POS_TOP, 0));
        pend_q.push_back(make_tick(8388607, 8388607, -1048576, 65535, 12345, 67890));
        pend_q.push_back(make_tick(-8388608, -8388608, 1048575, 1, 0, 0));
        pend_q.push_back(make_tick(-1, -1, -1, 65535, 524288, 524288));
        pend_q.push_back(make_tick(1, 1, 1, 65535, 1, 1));
        pend_q.push_back(make_tick(-8388608, 0, 0, 65535, 700000, 100000));
        pend_q.push_back(make_tick(0, -8388608, 0, 65535, 100, 900000));
        pend_q.push_back(make_tick(0, 0, 32768, 65535, 491520, 276480));
        pend_q.push_back(make_tick(4096, -4096, 0, 256, 245760, 138240));
        drain();

        // coincident query point, then one just inside the d^2 clamp
        pend_q.push_back(make_tick(0, 0, 0, 0, int'(bx_pos), int'(by_pos)));
        drain();
        pend_q.push_back(make_tick(0, 0, 0, 0, int'(bx_pos) + (bx_pos > 0 ? -1 : 1),
                                   int'(by_pos)));
        drain();

        // strongest attraction, zero width acting as 4096
        set_world(32'hFFFF_FFFF, 12'd0, 12'd4095);
        pend_q.push_back(make_tick(0, 0, 0, 0, int'(bx_pos), int'(by_pos)));
        pend_q.push_back(make_tick(0, 0, 0, 0, int'(bx_pos) + 3, int'(by_pos)));
        repeat (400) pend_q.push_back(rand_tick());
        drain();

        // sustained pushes to saturate velocity both ways
        repeat (150) pend_q.push_back(make_tick(8388607, -8388608, 1048575, 65535,
                                                $urandom_range(0, POS_TOP),
                                                $urandom_range(0, POS_TOP)));
        repeat (150) pend_q.push_back(make_tick(-8388608, 8388607, -1048576, 65535,
                                                $urandom_range(0, POS_TOP),
                                                $urandom_range(0, POS_TOP)));
        drain();

        // tiny world: old position lies beyond the new span
        set_world(32'd0, 12'd1, 12'd1);
        repeat (300) pend_q.push_back(rand_tick());
        drain();

        repeat (4)
        begin
            g = $urandom;
            set_world(32'(g >> $urandom_range(0, 31)), 12'($urandom_range(0, 4095)),
                      12'($urandom_range(1, 4095)));
            repeat (200) pend_q.push_back(rand_tick());
            drain();
        end

        $display("Covered %0d ticks and %0d checked results over several world settings,",
                 n_ticks, n_results);
        $display("including saturation, coincident points and a long output hold-off.");
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
